// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== design/ile_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared widths, limits, types and helpers of the lattice energy block
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int SIDE_MAX_DEF = 64;
  localparam int TEMPS_DEF    = 64;

  localparam int SIZE_W   = 7;
  localparam int TEMP_W   = 6;
  localparam int ENERGY_W = 15;
  localparam int TOTAL_W  = 25;

  localparam int ENERGY_MAX = 8192;
  localparam int TOTAL_MAX  = 8388608;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - TEMP_W - ENERGY_W - TOTAL_W;

  localparam logic [SIZE_W-1:0] LATTICE_SIZE_RST = 7'd64;

  // finished lattice handed to the totals stage
  typedef struct packed {
    logic                       valid;
    logic [TEMP_W-1:0]          temp;
    logic signed [ENERGY_W-1:0] energy;
  } tot_req_t;

  // pipeline control from the totals stage
  typedef struct packed {
    logic adv;
    logic clearing;
  } tot_ctl_t;

  // +1 for equal spins, -1 otherwise
  function automatic logic signed [2:0] bond(input logic a, input logic b);
    return (a == b) ? 3'sd1 : -3'sd1;
  endfunction

endpackage

// ===== design/ising_lattice_energy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_lattice_energy
// Periodic 2D Ising lattice energy with per-temperature running totals
// ----------------------------------------------------------------------------
// Spins of an N by N lattice stream in raster order, one per transfer, and the
// block sustains one spin per clock unless stalled. The column's upper and
// first-row spins come from two line-buffer memories read at the spin's
// column, and each spin costs one read and one small add into the bond sum.
// The last spin's result passes the p1 registers, the totals read stage and
// the result register, with the totals memory read, updated with saturation
// and written back on the way. After reset the totals memory is swept to zero
// with s_axis_tready low; configuration writes are taken throughout. Beyond
// that sweep, the input stalls only when a finished result waits on the output
// and the next finished lattice has reached the totals stage.
module ising_lattice_energy #(
  parameter int SIDE_MAX = ile_pkg::SIDE_MAX_DEF,
  parameter int TEMPS    = ile_pkg::TEMPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ile_pkg::SIZE_W-1:0]         cfg_wdata,      // lattice_size
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ile_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // spin, temp_index
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // result_temp_index, lattice_energy, temperature_total
  output logic [ile_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import ile_pkg::*;

  localparam int CW  = $clog2(SIDE_MAX);
  localparam int XW  = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int BW0 = $clog2(2 * SIDE_MAX * SIDE_MAX + 1) + 1;
  localparam int BW  = (BW0 > ENERGY_W) ? BW0 : ENERGY_W;

  logic [SIZE_W-1:0] lattice_size;
  logic [XW-1:0]     size_x;
  logic [XW-1:0]     nm1_x;
  logic [CW-1:0]     nm1;

  logic              spin;
  logic [TEMP_W-1:0] temp_in;
  logic              accept;
  tot_ctl_t          ctl;

  logic [CW-1:0]     row;
  logic [CW-1:0]     col;
  logic              prev_spin;
  logic              row_start;
  logic [TEMP_W-1:0] cur_temp;
  logic              col_last;
  logic              row_last;
  logic              first;
  logic signed [2:0] hdelta;

  logic              prev_q;
  logic              first_q;

  logic              p1_valid;
  logic              p1_spin;
  logic signed [2:0] p1_h;
  logic              p1_rnz;
  logic              p1_rlast;
  logic              p1_first;
  logic              p1_last;
  logic [TEMP_W-1:0] p1_temp;

  logic signed [BW-1:0]       bond_sum;
  logic signed [2:0]          vdelta;
  logic signed [BW-1:0]       base;
  logic signed [BW-1:0]       sum_next;
  logic signed [BW:0]         neg;
  logic signed [ENERGY_W-1:0] energy;
  tot_req_t                   req;

  logic                       res_valid;
  logic [TEMP_W-1:0]          res_temp;
  logic signed [ENERGY_W-1:0] res_energy;
  logic signed [TOTAL_W-1:0]  res_total;

  // effective side clamped to [2, SIDE_MAX], kept as side minus one
  always_comb begin
    size_x = XW'(lattice_size);
    priority if (size_x < XW'(2)) begin
      nm1_x = XW'(1);
    end else if (size_x > XW'(SIDE_MAX)) begin
      nm1_x = XW'(SIDE_MAX - 1);
    end else begin
      nm1_x = size_x - XW'(1);
    end
    nm1 = nm1_x[CW-1:0];
  end

  assign spin          = s_axis_tdata[0];
  assign temp_in       = s_axis_tdata[TEMP_W:1];
  assign s_axis_tready = ctl.adv && !ctl.clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign col_last = col == nm1;
  assign row_last = row == nm1;
  assign first    = (row == '0) && (col == '0);

  // horizontal bonds: left neighbor, and the row wrap at the last column
  always_comb begin
    hdelta = 3'sd0;
    if (col != '0) begin
      hdelta = hdelta + bond(spin, prev_spin);
    end
    if (col_last) begin
      hdelta = hdelta + bond(spin, row_start);
    end
  end

  ile_line_buf #(
    .DEPTH(SIDE_MAX)
  ) u_line_buf (
    .clk     (clk),
    .en      (accept),
    .addr    (col),
    .spin    (spin),
    .first_we(accept && (row == '0)),
    .prev_q  (prev_q),
    .first_q (first_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_size <= LATTICE_SIZE_RST;
      row          <= '0;
      col          <= '0;
      prev_spin    <= 1'b0;
      row_start    <= 1'b0;
      cur_temp     <= '0;
      p1_valid     <= 1'b0;
      bond_sum     <= '0;
    end else begin
      if (cfg_we) begin
        lattice_size <= cfg_wdata;
        row          <= '0;
        col          <= '0;
        bond_sum     <= '0;
      end else begin
        if (accept) begin
          prev_spin <= spin;
          if (col == '0) begin
            row_start <= spin;
          end
          if (first) begin
            cur_temp <= temp_in;
          end
          if (col_last) begin
            col <= '0;
            row <= row_last ? '0 : row + CW'(1);
          end else begin
            col <= col + CW'(1);
          end
        end
        if (ctl.adv && p1_valid) begin
          bond_sum <= sum_next;
        end
      end
      if (ctl.adv) begin
        p1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_spin  <= spin;
      p1_h     <= hdelta;
      p1_rnz   <= row != '0;
      p1_rlast <= row_last;
      p1_first <= first;
      p1_last  <= row_last && col_last;
      p1_temp  <= first ? temp_in : cur_temp;
    end
  end

  // vertical bonds from the line buffers, then accumulate and saturate
  always_comb begin
    vdelta = 3'sd0;
    if (p1_rnz) begin
      vdelta = vdelta + bond(p1_spin, prev_q);
    end
    if (p1_rlast) begin
      vdelta = vdelta + bond(p1_spin, first_q);
    end
    base     = p1_first ? '0 : bond_sum;
    sum_next = base + BW'(p1_h) + BW'(vdelta);
    neg      = -((BW+1)'(sum_next));
    priority if (neg > ENERGY_MAX) begin
      energy = ENERGY_W'(ENERGY_MAX);
    end else if (neg < -ENERGY_MAX) begin
      energy = ENERGY_W'(-ENERGY_MAX);
    end else begin
      energy = neg[ENERGY_W-1:0];
    end
    req.valid  = p1_valid && p1_last;
    req.temp   = p1_temp;
    req.energy = energy;
  end

  ile_totals #(
    .TEMPS(TEMPS)
  ) u_totals (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_ready (m_axis_tready),
    .ctl       (ctl),
    .res_valid (res_valid),
    .res_temp  (res_temp),
    .res_energy(res_energy),
    .res_total (res_total)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_total, res_energy, res_temp};

endmodule

// ===== design/ile_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_line_buf
// Previous-row and first-row spin memories, read and written per column
// ----------------------------------------------------------------------------
module ile_line_buf #(
  parameter int DEPTH = ile_pkg::SIDE_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     spin,
  input  logic                     first_we,
  output logic                     prev_q,
  output logic                     first_q
);
  import ile_pkg::*;

  logic prev_mem  [DEPTH];
  logic first_mem [DEPTH];

  // read returns the value held before this write
  always_ff @(posedge clk) begin
    if (en) begin
      prev_q         <= prev_mem[addr];
      first_q        <= first_mem[addr];
      prev_mem[addr] <= spin;
      if (first_we) begin
        first_mem[addr] <= spin;
      end
    end
  end

endmodule

// ===== design/ile_totals.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_totals
// Per-temperature running totals: clearing sweep, read-modify-write with
// saturation, and the result output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ile_totals #(
  parameter int TEMPS = ile_pkg::TEMPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ile_pkg::tot_req_t                   req,
  input  logic                                out_ready,
  output ile_pkg::tot_ctl_t                   ctl,
  output logic                                res_valid,
  output logic [ile_pkg::TEMP_W-1:0]          res_temp,
  output logic signed [ile_pkg::ENERGY_W-1:0] res_energy,
  output logic signed [ile_pkg::TOTAL_W-1:0]  res_total
);
  import ile_pkg::*;

  localparam int TW  = (TEMPS > 1) ? $clog2(TEMPS) : 1;
  localparam int TXW = (TW > TEMP_W) ? TW : TEMP_W;

  logic [TOTAL_W-1:0] mem [TEMPS];

  logic                       clearing;
  logic [TW-1:0]              clr_addr;
  logic                       p2_valid;
  logic [TEMP_W-1:0]          p2_temp;
  logic signed [ENERGY_W-1:0] p2_energy;
  logic                       p2_in_range;
  logic [TW-1:0]              p2_addr;
  logic signed [TOTAL_W-1:0]  rd_q;

  logic                      adv;
  logic [TXW-1:0]            req_x;
  logic [TW-1:0]             req_addr;
  logic                      req_in_range;
  logic signed [TOTAL_W:0]   sum;
  logic signed [TOTAL_W-1:0] sum_sat;
  logic signed [TOTAL_W-1:0] total;

  assign adv          = !(p2_valid && res_valid && !out_ready);
  assign ctl.adv      = adv;
  assign ctl.clearing = clearing;

  assign req_x        = TXW'(req.temp);
  assign req_addr     = req_x[TW-1:0];
  assign req_in_range = int'(req.temp) < TEMPS;

  always_comb begin
    sum = (TOTAL_W+1)'(rd_q) + (TOTAL_W+1)'(p2_energy);
    priority if (sum > TOTAL_MAX) begin
      sum_sat = TOTAL_W'(TOTAL_MAX);
    end else if (sum < -TOTAL_MAX) begin
      sum_sat = TOTAL_W'(-TOTAL_MAX);
    end else begin
      sum_sat = sum[TOTAL_W-1:0];
    end
    total = p2_in_range ? sum_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (adv && p2_valid && p2_in_range) begin
      mem[p2_addr] <= total;
    end
    if (adv && req.valid) begin
      rd_q <= mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      p2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + TW'(1);
        if (clr_addr == TW'(TEMPS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (adv) begin
        p2_valid <= req.valid;
      end
      if (adv && p2_valid) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req.valid) begin
      p2_temp     <= req.temp;
      p2_energy   <= req.energy;
      p2_in_range <= req_in_range;
      p2_addr     <= req_addr;
    end
    if (adv && p2_valid) begin
      res_temp   <= p2_temp;
      res_energy <= p2_energy;
      res_total  <= total;
    end
  end

  `ASSERT_NEVER(a_no_update_in_clear, clk, rst, p2_valid && clearing)
  `ASSERT_CLK(a_result_loads, clk, rst, (p2_valid && adv) |=> res_valid)
  `ASSERT_CLK(a_stall_holds, clk, rst, (p2_valid && !adv) |=> p2_valid)
  `ASSERT_CLK(a_total_range, clk, rst,
              res_valid |-> (res_total <= TOTAL_MAX && res_total >= -TOTAL_MAX))

endmodule
